// ===== rtl/ccf_pkg.sv =====
package ccf_pkg;

    // coordinate and intermediate widths, sized from the input range
    localparam int P_W     = 16;              // input coordinate
    localparam int A_W     = P_W + 1;         // point differences
    localparam int N_W     = 35;              // normal n = a x b
    localparam int SQ_W    = 34;              // squared edge lengths
    localparam int X_W     = 52;              // b x n and n x a
    localparam int HALF_W  = X_W / 2;         // split of the wide products
    localparam int PP_W    = SQ_W + HALF_W;   // partial products
    localparam int NN_W    = 68;              // |n|^2
    localparam int DP_W    = NN_W + A_W;      // |n|^2 * start point
    localparam int T_W     = 88;              // center numerator, signed
    localparam int CN_W    = 98;              // center dividend
    localparam int CD_W    = NN_W + 2;        // center divisor, 4 |n|^2
    localparam int CQ_W    = 32;              // center quotient
    localparam int CMP_C_W = CD_W + CQ_W + 2; // center compare width
    localparam int ABC_W   = 104;             // |a|^2 |b|^2 |c|^2
    localparam int RN_W    = 120;             // radius dividend
    localparam int RQ_W    = 66;              // radius quotient
    localparam int CMP_R_W = NN_W + RQ_W + 2; // radius compare width
    localparam int RS_W    = 33;              // square root result
    localparam int SR_W    = 68;              // square root remainder
    localparam int RND_SH  = 9;               // q8 scale plus half for rounding
    localparam int RAD_SH  = 16;              // q8 scale squared

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_COLLINEAR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef struct packed {
        logic signed [P_W-1:0] start_x;
        logic signed [P_W-1:0] start_y;
        logic signed [P_W-1:0] start_z;
        logic signed [P_W-1:0] mid_x;
        logic signed [P_W-1:0] mid_y;
        logic signed [P_W-1:0] mid_z;
        logic signed [P_W-1:0] end_x;
        logic signed [P_W-1:0] end_y;
        logic signed [P_W-1:0] end_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [31:0] radius;
        logic        [1:0]  status;
    } t_out;

    // handed from the arithmetic front to the divider back end
    typedef struct packed {
        logic                  v;
        logic                  col;
        logic [2:0]            neg;
        logic [2:0][CN_W-1:0]  cn;
        logic [CD_W-1:0]       cd;
        logic [RN_W-1:0]       num;
        logic [NN_W-1:0]       nn;
    } t_fe;

endpackage

// ===== rtl/ccf_front.sv =====
module ccf_front import ccf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_pts,
    output t_fe  o_fe
);

    function automatic logic [SQ_W-1:0] sum_sq(input logic signed [A_W-1:0] x,
                                               input logic signed [A_W-1:0] y,
                                               input logic signed [A_W-1:0] z);
        logic signed [SQ_W+1:0] acc;
        acc = (SQ_W+2)'(x) * (SQ_W+2)'(x) + (SQ_W+2)'(y) * (SQ_W+2)'(y)
            + (SQ_W+2)'(z) * (SQ_W+2)'(z);
        return acc[SQ_W-1:0];
    endfunction

    logic [5:0] r_v;

    // stage 1
    logic signed [P_W-1:0] r_p1_1 [3];
    logic signed [A_W-1:0] r_a_1 [3];
    logic signed [A_W-1:0] r_b_1 [3];
    logic signed [A_W-1:0] r_c_1 [3];
    // stage 2
    logic signed [P_W-1:0] r_p1_2 [3];
    logic signed [A_W-1:0] r_a_2 [3];
    logic signed [A_W-1:0] r_b_2 [3];
    logic signed [N_W-1:0] r_n [3];
    logic [SQ_W-1:0]       r_aa_2, r_bb_2, r_cc_2;
    // stage 3
    logic signed [P_W-1:0] r_p1_3 [3];
    logic                  r_col_3;
    logic signed [X_W-1:0] r_bn [3];
    logic signed [X_W-1:0] r_na [3];
    logic [NN_W-1:0]       r_nsq [3];
    logic [NN_W-1:0]       r_ab;
    logic [SQ_W-1:0]       r_aa_3, r_bb_3, r_cc_3;
    // stage 4
    logic signed [P_W-1:0]  r_p1_4 [3];
    logic                   r_col_4;
    logic [PP_W-1:0]        r_pal [3];
    logic signed [PP_W:0]   r_pah [3];
    logic [PP_W-1:0]        r_pbl [3];
    logic signed [PP_W:0]   r_pbh [3];
    logic [NN_W-1:0]        r_nn_4;
    logic [NN_W-1:0]        r_abl, r_abh;
    // stage 5
    logic                   r_col_5;
    logic signed [T_W-1:0]  r_u [3];
    logic signed [DP_W-1:0] r_dp [3];
    logic [ABC_W-1:0]       r_abc;
    logic [NN_W-1:0]        r_nn_5;
    // stage 6
    logic                   r_col_6;
    logic [2:0]             r_neg;
    logic [CN_W-1:0]        r_cn [3];
    logic [CD_W-1:0]        r_cd;
    logic [RN_W-1:0]        r_num;
    logic [NN_W-1:0]        r_nn_6;

    logic signed [T_W-1:0]  n_t [3];
    logic [T_W-1:0]         n_mag [3];
    logic [2:0]             n_neg;
    logic [CN_W-1:0]        n_cn [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    // differences from the start point, and end minus middle point
    always_ff @(posedge i_clk) begin
        r_p1_1[0] <= i_pts.start_x;
        r_p1_1[1] <= i_pts.start_y;
        r_p1_1[2] <= i_pts.start_z;
        r_a_1[0]  <= A_W'(i_pts.mid_x) - A_W'(i_pts.start_x);
        r_a_1[1]  <= A_W'(i_pts.mid_y) - A_W'(i_pts.start_y);
        r_a_1[2]  <= A_W'(i_pts.mid_z) - A_W'(i_pts.start_z);
        r_b_1[0]  <= A_W'(i_pts.end_x) - A_W'(i_pts.start_x);
        r_b_1[1]  <= A_W'(i_pts.end_y) - A_W'(i_pts.start_y);
        r_b_1[2]  <= A_W'(i_pts.end_z) - A_W'(i_pts.start_z);
        r_c_1[0]  <= A_W'(i_pts.end_x) - A_W'(i_pts.mid_x);
        r_c_1[1]  <= A_W'(i_pts.end_y) - A_W'(i_pts.mid_y);
        r_c_1[2]  <= A_W'(i_pts.end_z) - A_W'(i_pts.mid_z);
    end

    // normal and squared lengths
    always_ff @(posedge i_clk) begin
        r_p1_2 <= r_p1_1;
        r_a_2  <= r_a_1;
        r_b_2  <= r_b_1;
        r_n[0] <= N_W'(r_a_1[1]) * N_W'(r_b_1[2]) - N_W'(r_a_1[2]) * N_W'(r_b_1[1]);
        r_n[1] <= N_W'(r_a_1[2]) * N_W'(r_b_1[0]) - N_W'(r_a_1[0]) * N_W'(r_b_1[2]);
        r_n[2] <= N_W'(r_a_1[0]) * N_W'(r_b_1[1]) - N_W'(r_a_1[1]) * N_W'(r_b_1[0]);
        r_aa_2 <= sum_sq(r_a_1[0], r_a_1[1], r_a_1[2]);
        r_bb_2 <= sum_sq(r_b_1[0], r_b_1[1], r_b_1[2]);
        r_cc_2 <= sum_sq(r_c_1[0], r_c_1[1], r_c_1[2]);
    end

    // b x n, n x a, squares of n, |a|^2 |b|^2, collinear flag
    always_ff @(posedge i_clk) begin
        r_p1_3  <= r_p1_2;
        r_col_3 <= (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);
        r_bn[0] <= X_W'(r_b_2[1]) * X_W'(r_n[2]) - X_W'(r_b_2[2]) * X_W'(r_n[1]);
        r_bn[1] <= X_W'(r_b_2[2]) * X_W'(r_n[0]) - X_W'(r_b_2[0]) * X_W'(r_n[2]);
        r_bn[2] <= X_W'(r_b_2[0]) * X_W'(r_n[1]) - X_W'(r_b_2[1]) * X_W'(r_n[0]);
        r_na[0] <= X_W'(r_n[1]) * X_W'(r_a_2[2]) - X_W'(r_n[2]) * X_W'(r_a_2[1]);
        r_na[1] <= X_W'(r_n[2]) * X_W'(r_a_2[0]) - X_W'(r_n[0]) * X_W'(r_a_2[2]);
        r_na[2] <= X_W'(r_n[0]) * X_W'(r_a_2[1]) - X_W'(r_n[1]) * X_W'(r_a_2[0]);
        for (int i = 0; i < 3; i++) begin
            r_nsq[i] <= $unsigned(NN_W'(r_n[i]) * NN_W'(r_n[i]));
        end
        r_ab   <= NN_W'(r_aa_2) * NN_W'(r_bb_2);
        r_aa_3 <= r_aa_2;
        r_bb_3 <= r_bb_2;
        r_cc_3 <= r_cc_2;
    end

    // partial products, wide operands split in halves
    always_ff @(posedge i_clk) begin
        r_p1_4  <= r_p1_3;
        r_col_4 <= r_col_3;
        for (int i = 0; i < 3; i++) begin
            r_pal[i] <= PP_W'(r_aa_3) * PP_W'(r_bn[i][HALF_W-1:0]);
            r_pah[i] <= (PP_W+1)'($signed({1'b0, r_aa_3}))
                      * (PP_W+1)'($signed(r_bn[i][X_W-1:HALF_W]));
            r_pbl[i] <= PP_W'(r_bb_3) * PP_W'(r_na[i][HALF_W-1:0]);
            r_pbh[i] <= (PP_W+1)'($signed({1'b0, r_bb_3}))
                      * (PP_W+1)'($signed(r_na[i][X_W-1:HALF_W]));
        end
        r_nn_4 <= r_nsq[0] + r_nsq[1] + r_nsq[2];
        r_abl  <= NN_W'(r_ab[SQ_W-1:0]) * NN_W'(r_cc_3);
        r_abh  <= NN_W'(r_ab[2*SQ_W-1:SQ_W]) * NN_W'(r_cc_3);
    end

    // recombine, start point term
    always_ff @(posedge i_clk) begin
        r_col_5 <= r_col_4;
        for (int i = 0; i < 3; i++) begin
            r_u[i] <= (T_W'(r_pah[i]) <<< HALF_W) + T_W'($signed({1'b0, r_pal[i]}))
                    + (T_W'(r_pbh[i]) <<< HALF_W) + T_W'($signed({1'b0, r_pbl[i]}));
            r_dp[i] <= DP_W'($signed({1'b0, r_nn_4})) * DP_W'(r_p1_4[i]);
        end
        r_abc  <= (ABC_W'(r_abh) << SQ_W) + ABC_W'(r_abl);
        r_nn_5 <= r_nn_4;
    end

    // sign and magnitude, dividends for rounding
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i]   = (T_W'(r_dp[i]) <<< 1) + r_u[i];
            n_neg[i] = n_t[i][T_W-1];
            n_mag[i] = n_neg[i] ? T_W'(-n_t[i]) : T_W'(n_t[i]);
            n_cn[i]  = (CN_W'(n_mag[i]) << RND_SH) + CN_W'({r_nn_5, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_6 <= r_col_5;
        r_neg   <= n_neg;
        r_cn    <= n_cn;
        r_cd    <= {r_nn_5, 2'b00};
        r_num   <= RN_W'(r_abc) << RAD_SH;
        r_nn_6  <= r_nn_5;
    end

    always_comb begin
        o_fe.v   = r_v[5];
        o_fe.col = r_col_6;
        o_fe.neg = r_neg;
        for (int i = 0; i < 3; i++) begin
            o_fe.cn[i] = r_cn[i];
        end
        o_fe.cd  = r_cd;
        o_fe.num = r_num;
        o_fe.nn  = r_nn_6;
    end

endmodule

// ===== rtl/ccf_back.sv =====
module ccf_back import ccf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_fe  i_fe,
    output logic o_done,
    output t_out o_result
);

    localparam int DIV_STEPS = RQ_W + 1;
    localparam int C_STEPS   = CQ_W + 1;
    localparam logic [CQ_W-1:0] C_MAX = {1'b0, {(CQ_W-1){1'b1}}};
    localparam logic [CQ_W-1:0] C_MIN = {1'b1, {(CQ_W-1){1'b0}}};

    typedef struct packed {
        logic                  v;
        logic                  col;
        logic [2:0]            neg;
        logic [2:0]            cov;
        logic [2:0][CN_W-1:0]  cr;
        logic [2:0][CQ_W-1:0]  cq;
        logic [CD_W-1:0]       cd;
        logic                  rov;
        logic [RN_W-1:0]       rr;
        logic [RQ_W-1:0]       rq;
        logic [NN_W-1:0]       rd;
    } t_dv;

    typedef struct packed {
        logic                  v;
        logic                  col;
        logic                  rov;
        logic [2:0]            neg;
        logic [2:0]            cov;
        logic [2:0][CQ_W-1:0]  cq;
        logic [SR_W-1:0]       rem;
        logic [RS_W-1:0]       s;
    } t_sq;

    t_dv dv_in;
    t_dv r_dv [DIV_STEPS];
    t_dv n_dv [DIV_STEPS];
    t_sq sq_in;
    t_sq r_sq [RS_W];
    t_sq n_sq [RS_W];
    t_sq fin;
    t_out n_out;
    t_out r_out;
    logic r_done;

    always_comb begin
        dv_in     = '0;
        dv_in.v   = i_fe.v;
        dv_in.col = i_fe.col;
        dv_in.neg = i_fe.neg;
        dv_in.cr  = i_fe.cn;
        dv_in.cd  = i_fe.cd;
        dv_in.rr  = i_fe.num;
        dv_in.rd  = i_fe.nn;
    end

    // restoring division, one quotient bit per stage; the first stage only
    // flags quotients that cannot fit
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        t_dv src;
        if (k == 0) begin : g_first
            assign src = dv_in;
            always_comb begin
                n_dv[k]     = src;
                n_dv[k].rov = CMP_R_W'(src.rr) >= (CMP_R_W'(src.rd) << RQ_W);
                for (int i = 0; i < 3; i++) begin
                    n_dv[k].cov[i] = CMP_C_W'(src.cr[i]) >= (CMP_C_W'(src.cd) << CQ_W);
                end
            end
        end else begin : g_step
            localparam int RB = RQ_W - k;
            localparam int CB = (k < C_STEPS) ? CQ_W - k : 0;
            assign src = r_dv[k-1];
            always_comb begin
                logic [CMP_R_W-1:0] rsh;
                logic [CMP_C_W-1:0] csh;
                n_dv[k] = src;
                rsh = CMP_R_W'(src.rd) << RB;
                if (CMP_R_W'(src.rr) >= rsh) begin
                    n_dv[k].rr     = src.rr - RN_W'(rsh);
                    n_dv[k].rq[RB] = 1'b1;
                end
                csh = CMP_C_W'(src.cd) << CB;
                if (k < C_STEPS) begin
                    for (int i = 0; i < 3; i++) begin
                        if (CMP_C_W'(src.cr[i]) >= csh) begin
                            n_dv[k].cr[i]     = src.cr[i] - CN_W'(csh);
                            n_dv[k].cq[i][CB] = 1'b1;
                        end
                    end
                end
            end
        end
        // valid bit cleared by reset, data not reset
        always_ff @(posedge i_clk) begin
            r_dv[k] <= {n_dv[k].v & i_rst_n, n_dv[k][$bits(t_dv)-2:0]};
        end
    end

    always_comb begin
        sq_in     = '0;
        sq_in.v   = r_dv[DIV_STEPS-1].v;
        sq_in.col = r_dv[DIV_STEPS-1].col;
        sq_in.rov = r_dv[DIV_STEPS-1].rov;
        sq_in.neg = r_dv[DIV_STEPS-1].neg;
        sq_in.cov = r_dv[DIV_STEPS-1].cov;
        sq_in.cq  = r_dv[DIV_STEPS-1].cq;
        sq_in.rem = SR_W'(r_dv[DIV_STEPS-1].rq);
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < RS_W; k++) begin : g_sqrt
        localparam int SB = RS_W - 1 - k;
        t_sq src;
        if (k == 0) begin : g_first
            assign src = sq_in;
        end else begin : g_next
            assign src = r_sq[k-1];
        end
        always_comb begin
            logic [SR_W-1:0] trial;
            n_sq[k] = src;
            trial = (SR_W'(src.s) << (SB + 1)) | (SR_W'(1) << (2 * SB));
            if (src.rem >= trial) begin
                n_sq[k].rem   = src.rem - trial;
                n_sq[k].s[SB] = 1'b1;
            end
        end
        // valid bit cleared by reset, data not reset
        always_ff @(posedge i_clk) begin
            r_sq[k] <= {n_sq[k].v & i_rst_n, n_sq[k][$bits(t_sq)-2:0]};
        end
    end

    assign fin = r_sq[RS_W-1];

    // saturation, radius rounding, status
    always_comb begin
        logic [2:0]            c_ovf;
        logic [2:0][CQ_W-1:0]  cval;
        logic                  rad_ovf;
        logic [RS_W-1:0]       rnd;
        for (int i = 0; i < 3; i++) begin
            if (fin.neg[i]) begin
                c_ovf[i] = fin.cov[i] | (fin.cq[i][CQ_W-1] & (|fin.cq[i][CQ_W-2:0]));
                cval[i]  = c_ovf[i] ? C_MIN : CQ_W'(-fin.cq[i]);
            end else begin
                c_ovf[i] = fin.cov[i] | fin.cq[i][CQ_W-1];
                cval[i]  = c_ovf[i] ? C_MAX : fin.cq[i];
            end
        end
        rad_ovf = fin.rov | (&fin.s);
        rnd     = fin.s + RS_W'(1);
        n_out.center_x = $signed(cval[0]);
        n_out.center_y = $signed(cval[1]);
        n_out.center_z = $signed(cval[2]);
        n_out.radius   = rad_ovf ? '1 : rnd[RS_W-1:1];
        n_out.status   = (rad_ovf || (c_ovf != '0)) ? ST_OVERFLOW : ST_OK;
        if (fin.col) begin
            n_out        = '0;
            n_out.status = ST_COLLINEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= fin.v;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule

// ===== rtl/circle_center_from_three_points.sv =====
// circle through three points in 3d, fully pipelined
//
// input channel: a beat is taken at each rising edge where start is high and
// busy is low. busy never rises, so a new point triple can enter every cycle.
// i_pts carries start, middle and end point as signed 16-bit integers.
// output channel: o_done is high for exactly one cycle per beat, with center
// (signed q23.8) and radius (unsigned q24.8) and status on o_result. the
// receiver cannot hold results off, and none is needed: nothing stalls.
// throughput: one beat per cycle. the latency is set by the divider chain (67
// stages: an overflow check and one per bit of the 66-bit radius quotient) and
// the 33-stage square root, behind 6 multiply and add stages.
// results leave in start order. reset clears every stage valid bit, so no
// beat in flight at reset is delivered; datapath registers are not reset.
// status: ok, collinear (all fields zero) or overflow (saturated fields).
module circle_center_from_three_points import ccf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_pts,
    output logic o_done,
    output t_out o_result
);

    t_fe fe;

    // the pipeline takes a beat every cycle
    assign busy = 1'b0;

    // differences, cross products and wide products, six stages
    ccf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_pts   (i_pts),
        .o_fe    (fe)
    );

    // bit-per-stage dividers, square root, saturation and output register
    ccf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fe     (fe),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== verif/circle_center_from_three_points_tb.sv =====
module circle_center_from_three_points_tb import ccf_pkg::*;;

    // drain margin, longer than the pipeline depth
    localparam int DRAIN_CYCLES = 140;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1230;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_pts;
    logic o_done;
    t_out o_result;

    circle_center_from_three_points DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_pts    (i_pts),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    t_in  pending_triples[$];   // triples not yet sent
    t_out expected_circles[$];  // predicted results in send order
    int   mismatches = 0;
    int   cycle_cnt  = 0;
    int   gap_left   = 0;
    bit   no_gaps    = 0;       // burst mode: back-to-back beats

    // integer square root of a 128-bit value, rounded down
    function automatic logic [127:0] isqrt128(logic [127:0] v);
        logic [127:0] root;
        logic [127:0] probe;
        root  = '0;
        probe = 128'd1 << 126;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // circumcenter and radius of one triple, computed exactly then rounded once
    function automatic t_out circumcircle(t_in pt);
        longint p1[3], pm[3], pe[3], a[3], b[3], c[3], n[3], bn[3], na[3];
        longint a2, b2, c2;
        logic signed [127:0] nn, den, acc, mag, q;
        logic signed [127:0] wa2, wb2, wbn, wna, wp;
        logic [127:0] num, s, m;
        logic [31:0] field[3];
        bit   ovf;
        bit   neg;
        t_out r;
        p1[0] = pt.start_x; p1[1] = pt.start_y; p1[2] = pt.start_z;
        pm[0] = pt.mid_x;   pm[1] = pt.mid_y;   pm[2] = pt.mid_z;
        pe[0] = pt.end_x;   pe[1] = pt.end_y;   pe[2] = pt.end_z;
        for (int i = 0; i < 3; i++) begin
            a[i] = pm[i] - p1[i];
            b[i] = pe[i] - p1[i];
            c[i] = b[i] - a[i];
        end
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        r = '0;
        // degenerate: coincident or collinear points
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.status = ST_COLLINEAR;
            return r;
        end
        a2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        b2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
        c2 = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
        bn[0] = b[1] * n[2] - b[2] * n[1];
        bn[1] = b[2] * n[0] - b[0] * n[2];
        bn[2] = b[0] * n[1] - b[1] * n[0];
        na[0] = n[1] * a[2] - n[2] * a[1];
        na[1] = n[2] * a[0] - n[0] * a[2];
        na[2] = n[0] * a[1] - n[1] * a[0];
        nn = 0;
        for (int i = 0; i < 3; i++) begin
            wp = n[i];
            nn = nn + wp * wp;
        end
        den = nn <<< 1;
        wa2 = a2;
        wb2 = b2;
        ovf = 0;
        for (int i = 0; i < 3; i++) begin
            wp  = p1[i];
            wbn = bn[i];
            wna = na[i];
            acc = den * wp + wa2 * wbn + wb2 * wna;
            neg = acc < 0;
            mag = neg ? -acc : acc;
            // q8 scale with round half away from zero
            q = ((mag <<< 9) + den) / (den <<< 1);
            if (neg)
                q = -q;
            if (q > 128'sd2147483647) begin
                ovf = 1;
                field[i] = 32'h7FFF_FFFF;
            end else if (q < -128'sd2147483648) begin
                ovf = 1;
                field[i] = 32'h8000_0000;
            end else begin
                field[i] = q[31:0];
            end
        end
        num = ((128'(a2) * 128'(b2)) * 128'(c2)) << 16;
        s = isqrt128(num / 128'(nn));
        m = (s + 1) >> 1;
        if (m > 128'hFFFF_FFFF) begin
            ovf = 1;
            r.radius = 32'hFFFF_FFFF;
        end else begin
            r.radius = m[31:0];
        end
        r.center_x = field[0];
        r.center_y = field[1];
        r.center_z = field[2];
        r.status   = ovf ? ST_OVERFLOW : ST_OK;
        return r;
    endfunction

    function automatic t_in make_triple(int sx, int sy, int sz, int mx, int my, int mz,
                                        int ex, int ey, int ez);
        t_in t;
        t.start_x = sx[15:0]; t.start_y = sy[15:0]; t.start_z = sz[15:0];
        t.mid_x   = mx[15:0]; t.mid_y   = my[15:0]; t.mid_z   = mz[15:0];
        t.end_x   = ex[15:0]; t.end_y   = ey[15:0]; t.end_z   = ez[15:0];
        return t;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", fname, want, got);
        end
    endtask

    // driver: one beat per queued triple, random gap between beats, none in burst mode
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_pts    <= '0;
            gap_left <= 0;
        end else if (start && busy) begin
            // held off, keep the beat on the bus
        end else begin
            if (start)
                expected_circles.push_back(circumcircle(i_pts));
            if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_triples.size() > 0) begin
                i_pts    <= pending_triples.pop_front();
                start    <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    no_gaps = ~no_gaps;
                gap_left <= no_gaps ? 0 : $urandom_range(0, 14);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (expected_circles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", o_result);
            end else begin
                want = expected_circles.pop_front();
                check_field("center_x", want.center_x, o_result.center_x);
                check_field("center_y", want.center_y, o_result.center_y);
                check_field("center_z", want.center_z, o_result.center_z);
                check_field("radius", want.radius, o_result.radius);
                check_field("status", 32'(want.status), 32'(o_result.status));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("circle_center_from_three_points regression: fail");
            $finish;
        end
    end

    initial begin
        int sx, sy, sz, dx, dy, dz, k, j, sel;
        i_rst_n = 1'b0;

        // directed: extremes, degenerate triples, overflow cases
        pending_triples.push_back(make_triple(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_triples.push_back(make_triple(5, -7, 9, 5, -7, 9, 5, -7, 9));
        pending_triples.push_back(make_triple(1, 2, 3, 1, 2, 3, 40, 50, 60));
        pending_triples.push_back(make_triple(0, 0, 0, 1, 1, 1, 2, 2, 2));
        pending_triples.push_back(make_triple(-32768, -32768, -32768, 0, 0, 0,
                                              32767, 32767, 32767));
        pending_triples.push_back(make_triple(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_triples.push_back(make_triple(1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_triples.push_back(make_triple(-32768, -32768, -32768, 32767, -32768,
                                              -32768, -32768, 32767, 32767));
        pending_triples.push_back(make_triple(32767, 32767, 32767, -32768, 32767,
                                              32767, 32767, -32768, -32768));
        pending_triples.push_back(make_triple(-32768, 0, 32767, 32767, -32768, 0,
                                              0, 32767, -32768));
        pending_triples.push_back(make_triple(-32768, -32768, 0, 32767, 32767, 0,
                                              32767, 32766, 0));
        pending_triples.push_back(make_triple(-32768, -32768, -32768, 32767, 32767,
                                              32767, 32767, 32767, 32766));
        pending_triples.push_back(make_triple(-32768, 0, 0, 0, 1, 0, 32767, 0, 0));
        pending_triples.push_back(make_triple(0, 0, 0, 2, 0, 0, 1, 1, 0));
        pending_triples.push_back(make_triple(3, 4, 0, -3, 4, 0, 3, -4, 0));
        pending_triples.push_back(make_triple(-1, -1, -1, -1, -1, -1, 0, 0, 0));
        pending_triples.push_back(make_triple(0, 0, 0, 0, 0, 1, 0, 1, 1));
        pending_triples.push_back(make_triple(100, -200, 300, -400, 500, -600,
                                              700, 800, -900));
        pending_triples.push_back(make_triple(0, 0, 0, 32767, 1, 0, -32768, -1, 1));

        // random: uniform triples, near-collinear ones, small ones
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            sel = $urandom_range(0, 9);
            sx = $urandom_range(0, 65535) - 32768;
            sy = $urandom_range(0, 65535) - 32768;
            sz = $urandom_range(0, 65535) - 32768;
            if (sel < 5) begin
                pending_triples.push_back(make_triple(sx, sy, sz,
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535)));
            end else if (sel < 8) begin
                // points on or next to a line: collinear status and huge radii
                dx = $urandom_range(0, 200) - 100;
                dy = $urandom_range(0, 200) - 100;
                dz = $urandom_range(0, 200) - 100;
                k  = $urandom_range(0, 300) - 150;
                j  = $urandom_range(0, 300) - 150;
                pending_triples.push_back(make_triple(sx, sy, sz,
                    sx + k * dx, sy + k * dy, sz + k * dz,
                    sx + j * dx + $urandom_range(0, 2) - 1,
                    sy + j * dy + $urandom_range(0, 2) - 1,
                    sz + j * dz));
            end else begin
                sx = $urandom_range(0, 20) - 10;
                pending_triples.push_back(make_triple(sx, sx + 1, -sx,
                    $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                    $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10,
                    $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10));
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all beats sent, all results back, then the tail of the pipe
        do @(posedge i_clk);
        while (pending_triples.size() > 0 || start || expected_circles.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_circles.size() == 0)
            $display("circle_center_from_three_points regression: pass");
        else
            $display("circle_center_from_three_points regression: fail");
        $finish;
    end

endmodule

// ===== circle_center_from_three_points.f =====
rtl/ccf_pkg.sv
rtl/ccf_front.sv
rtl/ccf_back.sv
rtl/circle_center_from_three_points.sv
verif/circle_center_from_three_points_tb.sv
